// ===== sv/mafc_pkg.sv =====
package mafc_pkg;

  // frame limit, the byte index saturates here
  localparam int unsigned MAX_FRAME_BYTES = 65536;
  localparam int unsigned IDX_W = $clog2(MAX_FRAME_BYTES + 1);
  // common width for range compares (range end carries 17 bits)
  localparam int unsigned CMP_W = (IDX_W > 17) ? IDX_W : 17;

  // algorithm codes
  localparam logic [2:0] ALG_MODBUS = 3'd0;
  localparam logic [2:0] ALG_CCITT  = 3'd1;
  localparam logic [2:0] ALG_CRC32  = 3'd2;
  localparam logic [2:0] ALG_SUM8   = 3'd3;
  localparam logic [2:0] ALG_XOR8   = 3'd4;

  // byte order codes
  localparam logic [1:0] ORD_DEFAULT = 2'd0;
  localparam logic [1:0] ORD_LITTLE  = 2'd1;
  localparam logic [1:0] ORD_BIG     = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_ALGORITHM   = 2'd0;
  localparam logic [1:0] CFG_RANGE_START = 2'd1;
  localparam logic [1:0] CFG_RANGE_END   = 2'd2;
  localparam logic [1:0] CFG_BYTE_ORDER  = 2'd3;

  // polynomials and start values
  localparam logic [15:0] POLY_MODBUS = 16'hA001;
  localparam logic [15:0] POLY_CCITT  = 16'h1021;
  localparam logic [31:0] POLY_CRC32  = 32'hEDB88320;
  localparam logic [15:0] INIT_CRC16  = 16'hFFFF;
  localparam logic [31:0] INIT_CRC32  = 32'hFFFFFFFF;
  localparam logic [15:0] CCITT_MSB   = 16'h8000;

  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // control from the top level to the fold engine
  typedef struct packed {
    logic [2:0] alg;
    logic [1:0] order;
    logic       fold;
  } eng_ctrl_t;

  // one result beat, check_value in the lowest bits
  typedef struct packed {
    logic [31:0] wire_bytes;
    logic [2:0]  check_length;
    logic [31:0] check_value;
  } result_t;

  // reserved algorithm codes act as crc16 modbus
  function automatic logic [2:0] alg_map(logic [2:0] raw);
    logic [2:0] a;
    a = (raw > ALG_XOR8) ? ALG_MODBUS : raw;
    return a;
  endfunction

  function automatic logic [31:0] start_value(logic [2:0] alg);
    logic [31:0] v;
    case (alg)
      ALG_MODBUS, ALG_CCITT: v = {16'h0000, INIT_CRC16};
      ALG_CRC32:             v = INIT_CRC32;
      default:               v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/mafc_engine.sv =====
module mafc_engine (
  input  mafc_pkg::eng_ctrl_t ctrl_i,
  input  logic [31:0]         acc_i,
  input  logic [7:0]          byte_i,
  output logic [31:0]         acc_o,
  output mafc_pkg::result_t   result_o
);

  logic [15:0] crc_modbus;
  logic [15:0] crc_ccitt;
  logic [31:0] crc32;
  logic [31:0] folded;
  logic [31:0] value;
  logic [2:0]  len;
  logic        big;

  // one byte through each check, eight bit steps per crc
  always_comb begin
    crc_modbus = acc_i[15:0] ^ {8'h00, byte_i};
    crc_ccitt  = acc_i[15:0] ^ {byte_i, 8'h00};
    crc32      = acc_i ^ {24'h000000, byte_i};
    for (int k = 0; k < 8; k++) begin
      crc_modbus = crc_modbus[0] ? ((crc_modbus >> 1) ^ mafc_pkg::POLY_MODBUS)
                                 : (crc_modbus >> 1);
      crc_ccitt  = ((crc_ccitt & mafc_pkg::CCITT_MSB) != 16'h0000)
                 ? ((crc_ccitt << 1) ^ mafc_pkg::POLY_CCITT) : (crc_ccitt << 1);
      crc32      = crc32[0] ? ((crc32 >> 1) ^ mafc_pkg::POLY_CRC32) : (crc32 >> 1);
    end
    case (ctrl_i.alg)
      mafc_pkg::ALG_CCITT: folded = {16'h0000, crc_ccitt};
      mafc_pkg::ALG_CRC32: folded = crc32;
      mafc_pkg::ALG_SUM8:  folded = {24'h000000, acc_i[7:0] + byte_i};
      mafc_pkg::ALG_XOR8:  folded = {24'h000000, acc_i[7:0] ^ byte_i};
      default:             folded = {16'h0000, crc_modbus};
    endcase
    acc_o = ctrl_i.fold ? folded : acc_i;
  end

  // final value, length and send order
  always_comb begin
    case (ctrl_i.alg)
      mafc_pkg::ALG_CCITT: begin
        value = {16'h0000, acc_o[15:0]};
        len   = mafc_pkg::LEN_TWO;
        big   = 1'b1;
      end
      mafc_pkg::ALG_CRC32: begin
        value = ~acc_o;
        len   = mafc_pkg::LEN_FOUR;
        big   = 1'b1;
      end
      mafc_pkg::ALG_SUM8, mafc_pkg::ALG_XOR8: begin
        value = {24'h000000, acc_o[7:0]};
        len   = mafc_pkg::LEN_ONE;
        big   = 1'b0;
      end
      default: begin
        value = {16'h0000, acc_o[15:0]};
        len   = mafc_pkg::LEN_TWO;
        big   = 1'b0;
      end
    endcase
    if (ctrl_i.order == mafc_pkg::ORD_LITTLE) begin
      big = 1'b0;
    end else if (ctrl_i.order == mafc_pkg::ORD_BIG) begin
      big = 1'b1;
    end
    result_o.check_value  = value;
    result_o.check_length = len;
    if (len == mafc_pkg::LEN_ONE || !big) begin
      result_o.wire_bytes = value;
    end else if (len == mafc_pkg::LEN_TWO) begin
      result_o.wire_bytes = {16'h0000, value[7:0], value[15:8]};
    end else begin
      result_o.wire_bytes = {value[7:0], value[15:8], value[23:16], value[31:24]};
    end
  end

endmodule

// ===== sv/multi_algorithm_frame_checksum.sv =====
// Frame check generator: crc16 modbus, crc16 ccitt, crc32, sum8 or xor8.
// Slave stream: one frame byte per beat in s_axis_tdata[7:0], s_axis_tlast
// on the final byte. Bytes whose index lies in [range_start, range_end] are
// folded; a negative range end means through the end of the frame. The
// byte index saturates at the frame limit and bytes beyond it are ignored.
// Master stream: one beat per frame, issued for the byte that carries tlast.
// Config channel: cfg_index_i selects algorithm, range_start, range_end or
// byte_order; always ready. Writing the algorithm restarts the frame.
// Throughput: one byte per cycle while s_axis_tready is high; the whole
// crc byte step is done in the accept cycle into the accumulator register.
// Output: the result for the last byte is registered into the output
// register, or into the skid register while the output register is busy.
// Stall: a held result stays on the output register, a second result goes
// into a skid register; s_axis_tready drops only while the skid is full.
// Reset: registers return to their defaults (crc16 modbus, full range,
// default order), the accumulator holds the modbus start value, no beat.
module multi_algorithm_frame_checksum (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream, tdata: data_byte[7:0]; tlast: frame_last
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  // master stream, tdata: check_value[31:0], check_length[34:32],
  // wire_bytes[66:35], zero pad[71:67]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned IdxW = mafc_pkg::IDX_W;
  localparam int unsigned CmpW = mafc_pkg::CMP_W;

  logic [2:0]  algorithm_q;
  logic [15:0] range_start_q;
  logic [16:0] range_end_q;
  logic [1:0]  byte_order_q;

  logic [31:0]     acc_q, acc_d;
  logic [IdxW-1:0] idx_q, idx_d;

  mafc_pkg::result_t result, out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  mafc_pkg::eng_ctrl_t ctrl;
  logic [31:0]         acc_next;
  logic [2:0]          alg_sel;
  logic                in_accept, cfg_accept, produce, out_pop, in_range;
  logic [CmpW-1:0]     idx_x, start_x, end_x;

  assign cfg_ready_o   = 1'b1;
  assign cfg_accept    = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready = ~skid_valid_q;
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign produce       = in_accept & s_axis_tlast;
  assign out_pop       = out_valid_q & m_axis_tready;
  assign alg_sel       = mafc_pkg::alg_map(algorithm_q);

  // range check on the current byte index
  always_comb begin
    idx_x    = CmpW'(idx_q);
    start_x  = CmpW'(range_start_q);
    end_x    = CmpW'(range_end_q[15:0]);
    in_range = (idx_q < IdxW'(mafc_pkg::MAX_FRAME_BYTES)) && (idx_x >= start_x) &&
               (range_end_q[16] || (idx_x <= end_x));
  end

  assign ctrl.alg   = alg_sel;
  assign ctrl.order = byte_order_q;
  assign ctrl.fold  = in_range;

  mafc_engine u_engine (
    .ctrl_i   (ctrl),
    .acc_i    (acc_q),
    .byte_i   (s_axis_tdata),
    .acc_o    (acc_next),
    .result_o (result)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      algorithm_q   <= mafc_pkg::ALG_MODBUS;
      range_start_q <= 16'h0000;
      range_end_q   <= 17'h1FFFF;
      byte_order_q  <= mafc_pkg::ORD_DEFAULT;
    end else if (cfg_accept) begin
      case (cfg_index_i)
        mafc_pkg::CFG_ALGORITHM:   algorithm_q   <= cfg_data_i[2:0];
        mafc_pkg::CFG_RANGE_START: range_start_q <= cfg_data_i[15:0];
        mafc_pkg::CFG_RANGE_END:   range_end_q   <= cfg_data_i[16:0];
        mafc_pkg::CFG_BYTE_ORDER:  byte_order_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // accumulator and byte index
  always_comb begin
    acc_d = acc_q;
    idx_d = idx_q;
    if (cfg_accept && cfg_index_i == mafc_pkg::CFG_ALGORITHM) begin
      acc_d = mafc_pkg::start_value(mafc_pkg::alg_map(cfg_data_i[2:0]));
      idx_d = '0;
    end else if (in_accept) begin
      if (s_axis_tlast) begin
        acc_d = mafc_pkg::start_value(alg_sel);
        idx_d = '0;
      end else begin
        acc_d = acc_next;
        if (idx_q != IdxW'(mafc_pkg::MAX_FRAME_BYTES)) begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= {16'h0000, mafc_pkg::INIT_CRC16};
      idx_q <= '0;
    end else begin
      acc_q <= acc_d;
      idx_q <= idx_d;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= produce;
      end else begin
        out_valid_q  <= produce;
      end
    end else if (produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_pop) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= result;
      end else begin
        out_q  <= result;
      end
    end else if (produce) begin
      skid_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q};

endmodule

// ===== sv/mafc_checker.sv =====
module mafc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  logic [31:0] value;
  logic [2:0]  len;
  logic [31:0] wire_b;

  assign value  = m_axis_tdata[31:0];
  assign len    = m_axis_tdata[34:32];
  assign wire_b = m_axis_tdata[66:35];

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // only lengths of one, two or four bytes
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (len == 3'd1 || len == 3'd2 || len == 3'd4))
    else $error("bad check length");

  // single byte checks send the value as is
  a_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && len == 3'd1 |-> value[31:8] == 24'h0 && wire_b == value)
    else $error("single byte check malformed");

  // two byte checks send the value in one order or the other
  a_two_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && len == 3'd2 |-> value[31:16] == 16'h0 && wire_b[31:16] == 16'h0 &&
      (wire_b[15:0] == value[15:0] || wire_b[15:0] == {value[7:0], value[15:8]}))
    else $error("two byte check malformed");

endmodule

bind multi_algorithm_frame_checksum mafc_checker u_mafc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int          TIMEOUT_NS       = 5_000_000;
  localparam int          SETTLE_CYCLES    = 4;
  localparam int          DRAIN_CYCLES     = 16;
  localparam int          HOLD_CYCLES      = 300;
  localparam int          RANDOM_PHASES    = 12;
  localparam int          BYTES_PER_PHASE  = 120;
  localparam logic [2:0]  ALG_RESERVED_TOP = 3'd7;
  localparam logic [1:0]  ORD_RESERVED     = 2'd3;
  localparam logic [15:0] MODBUS_POLY      = 16'hA001;
  localparam logic [15:0] CCITT_POLY       = 16'h1021;
  localparam logic [31:0] CRC32_POLY       = 32'hEDB88320;

  // one frame check as it leaves the block
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  len;
    logic [31:0] wire_order;
  } check_t;

  // directed stimulus: a register write or a frame byte
  typedef struct packed {
    bit          is_write;
    logic [1:0]  idx;
    logic [31:0] data;
    logic        last;
    bit          typed;
    check_t      want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  // predictor state
  logic [2:0]  cur_alg;
  logic [15:0] cur_start;
  logic [16:0] cur_end;
  logic [1:0]  cur_order;
  logic [31:0] crc_acc;
  int unsigned byte_pos;

  check_t      check_q [$];
  plan_row_t   plan [$];
  int          mismatches = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          hold_cycles = 0;
  int          snd_mode [4] = '{0, 66, 0, 16};
  int          rcv_mode [4] = '{0, 0, 66, 16};

  multi_algorithm_frame_checksum i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // reserved codes fold as crc16 modbus
  function automatic logic [2:0] active_alg();
    return (cur_alg > mafc_pkg::ALG_XOR8) ? mafc_pkg::ALG_MODBUS : cur_alg;
  endfunction

  function automatic void restart_frame();
    case (active_alg())
      mafc_pkg::ALG_MODBUS, mafc_pkg::ALG_CCITT: crc_acc = 32'h0000_FFFF;
      mafc_pkg::ALG_CRC32:                       crc_acc = 32'hFFFF_FFFF;
      default:                                   crc_acc = 32'h0000_0000;
    endcase
    byte_pos = 0;
  endfunction

  // one byte step of the selected check
  function automatic logic [31:0] fold_byte(logic [2:0] alg, logic [31:0] acc,
                                            logic [7:0] b);
    logic [31:0] r;
    logic [15:0] c;
    r = acc;
    case (alg)
      mafc_pkg::ALG_MODBUS: begin
        c = acc[15:0] ^ {8'h00, b};
        for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ MODBUS_POLY) : (c >> 1);
        r = {16'h0000, c};
      end
      mafc_pkg::ALG_CCITT: begin
        c = acc[15:0] ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ CCITT_POLY) : (c << 1);
        r = {16'h0000, c};
      end
      mafc_pkg::ALG_CRC32: begin
        r = acc ^ {24'h000000, b};
        for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC32_POLY) : (r >> 1);
      end
      mafc_pkg::ALG_SUM8: r = {24'h000000, acc[7:0] + b};
      default:            r = {24'h000000, acc[7:0] ^ b};
    endcase
    return r;
  endfunction

  // advance the predicted frame by one accepted byte
  task automatic advance_frame(input logic [7:0] b, input logic last,
                               output bit got, output check_t r);
    logic [2:0]  a;
    logic [31:0] v;
    logic [2:0]  n;
    bit          big;
    a   = active_alg();
    got = 1'b0;
    r   = '0;
    if (byte_pos < mafc_pkg::MAX_FRAME_BYTES && byte_pos >= cur_start &&
        (cur_end[16] || byte_pos <= cur_end))
      crc_acc = fold_byte(a, crc_acc, b);
    if (byte_pos < mafc_pkg::MAX_FRAME_BYTES) byte_pos++;
    if (last) begin
      case (a)
        mafc_pkg::ALG_MODBUS: begin
          v = {16'h0000, crc_acc[15:0]}; n = mafc_pkg::LEN_TWO;  big = 1'b0;
        end
        mafc_pkg::ALG_CCITT: begin
          v = {16'h0000, crc_acc[15:0]}; n = mafc_pkg::LEN_TWO;  big = 1'b1;
        end
        mafc_pkg::ALG_CRC32: begin
          v = ~crc_acc;                  n = mafc_pkg::LEN_FOUR; big = 1'b1;
        end
        default: begin
          v = {24'h000000, crc_acc[7:0]}; n = mafc_pkg::LEN_ONE; big = 1'b0;
        end
      endcase
      if (cur_order == mafc_pkg::ORD_LITTLE) big = 1'b0;
      else if (cur_order == mafc_pkg::ORD_BIG) big = 1'b1;
      r.value = v;
      r.len   = n;
      if (n == mafc_pkg::LEN_ONE || !big) r.wire_order = v;
      else if (n == mafc_pkg::LEN_TWO) r.wire_order = {16'h0000, v[7:0], v[15:8]};
      else r.wire_order = {v[7:0], v[15:8], v[23:16], v[31:24]};
      got = 1'b1;
      restart_frame();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %h, want %h at %0.1f ns", what, got, want, $realtime);
    mismatches++;
  endtask

  // stall the input side until every pending check has left the block
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (check_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // one register write beat, after which valid is dropped again
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      mafc_pkg::CFG_ALGORITHM: begin
        cur_alg = d[2:0];
        restart_frame();
      end
      mafc_pkg::CFG_RANGE_START: cur_start = d[15:0];
      mafc_pkg::CFG_RANGE_END:   cur_end = d[16:0];
      mafc_pkg::CFG_BYTE_ORDER:  cur_order = d[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // one frame byte beat; a typed check replaces the predicted one
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input check_t fixed);
    bit     got;
    check_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_frame(b, last, got, r);
    if (got) check_q.insert(check_q.size(), typed ? fixed : r);
    @(negedge clk_i);
  endtask

  function automatic plan_row_t byte_row(logic [7:0] b, logic last);
    plan_row_t p;
    p      = '0;
    p.data = {24'h000000, b};
    p.last = last;
    return p;
  endfunction

  function automatic plan_row_t reg_row(logic [1:0] idx, logic [31:0] d);
    plan_row_t p;
    p          = '0;
    p.is_write = 1'b1;
    p.idx      = idx;
    p.data     = d;
    return p;
  endfunction

  function automatic plan_row_t known_row(logic [7:0] b, logic [31:0] v, logic [2:0] n,
                                          logic [31:0] w);
    plan_row_t p;
    p                 = byte_row(b, 1'b1);
    p.typed           = 1'b1;
    p.want.value      = v;
    p.want.len        = n;
    p.want.wire_order = w;
    return p;
  endfunction

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // compare each result beat with the oldest pending check
  always @(posedge clk_i) begin
    check_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (check_q.size() == 0) begin
        report_mismatch("unexpected result beat", m_axis_tdata[31:0], 32'h0);
      end else begin
        want = check_q.pop_front();
        if (m_axis_tdata[31:0] !== want.value)
          report_mismatch("check_value", m_axis_tdata[31:0], want.value);
        if (m_axis_tdata[34:32] !== want.len)
          report_mismatch("check_length", {29'h0, m_axis_tdata[34:32]}, {29'h0, want.len});
        if (m_axis_tdata[66:35] !== want.wire_order)
          report_mismatch("wire_bytes", m_axis_tdata[66:35], want.wire_order);
        if (m_axis_tdata[71:67] !== 5'h00)
          report_mismatch("tdata padding", {27'h0, m_axis_tdata[71:67]}, 32'h0);
      end
    end
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("testbench failed");
    $finish;
  end

  initial begin
    int         sent;
    int         flen;
    logic [2:0] alg;
    logic [31:0] rs;
    logic [31:0] re;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = mafc_pkg::CFG_ALGORITHM;
    cfg_data_i    = 32'h0;
    rst_ni        = 1'b0;
    cur_alg       = mafc_pkg::ALG_MODBUS;
    cur_start     = 16'h0000;
    cur_end       = 17'h1FFFF;
    cur_order     = mafc_pkg::ORD_DEFAULT;
    restart_frame();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part
    plan = '{
      byte_row(8'h00, 1'b0), byte_row(8'hFF, 1'b1),
      // sum wraps to zero
      reg_row(mafc_pkg::CFG_ALGORITHM, {29'h0, mafc_pkg::ALG_SUM8}),
      byte_row(8'hFF, 1'b0), known_row(8'h01, 32'h00, mafc_pkg::LEN_ONE, 32'h00),
      reg_row(mafc_pkg::CFG_ALGORITHM, {29'h0, mafc_pkg::ALG_XOR8}),
      byte_row(8'hA5, 1'b0), known_row(8'h5A, 32'hFF, mafc_pkg::LEN_ONE, 32'hFF),
      reg_row(mafc_pkg::CFG_ALGORITHM, {29'h0, mafc_pkg::ALG_CCITT}),
      byte_row(8'h12, 1'b0), byte_row(8'h34, 1'b1),
      reg_row(mafc_pkg::CFG_BYTE_ORDER, {30'h0, mafc_pkg::ORD_LITTLE}),
      byte_row(8'h5A, 1'b1),
      reg_row(mafc_pkg::CFG_ALGORITHM, {29'h0, mafc_pkg::ALG_CRC32}),
      reg_row(mafc_pkg::CFG_BYTE_ORDER, {30'h0, mafc_pkg::ORD_BIG}),
      byte_row(8'h00, 1'b0), byte_row(8'hFF, 1'b1),
      // reserved order code falls back to the default
      reg_row(mafc_pkg::CFG_BYTE_ORDER, {30'h0, ORD_RESERVED}),
      byte_row(8'h80, 1'b1),
      // reserved algorithm code acts as modbus
      reg_row(mafc_pkg::CFG_ALGORITHM, {29'h0, ALG_RESERVED_TOP}),
      byte_row(8'h01, 1'b1),
      // start after end: nothing folded
      reg_row(mafc_pkg::CFG_RANGE_START, 32'd4), reg_row(mafc_pkg::CFG_RANGE_END, 32'd2),
      byte_row(8'h10, 1'b0), byte_row(8'h20, 1'b0),
      known_row(8'h30, 32'h0000FFFF, mafc_pkg::LEN_TWO, 32'h0000FFFF),
      // start at the top index, end negative: empty crc32
      reg_row(mafc_pkg::CFG_ALGORITHM, {29'h0, mafc_pkg::ALG_CRC32}),
      reg_row(mafc_pkg::CFG_BYTE_ORDER, {30'h0, mafc_pkg::ORD_DEFAULT}),
      reg_row(mafc_pkg::CFG_RANGE_START, 32'h0000FFFF),
      reg_row(mafc_pkg::CFG_RANGE_END, 32'hFFFFFFFF),
      known_row(8'h77, 32'h0, mafc_pkg::LEN_FOUR, 32'h0),
      // range end moved in the middle of a frame
      reg_row(mafc_pkg::CFG_RANGE_START, 32'd0), reg_row(mafc_pkg::CFG_RANGE_END, 32'd1),
      byte_row(8'h11, 1'b0), byte_row(8'h22, 1'b0), byte_row(8'h33, 1'b0),
      reg_row(mafc_pkg::CFG_RANGE_END, 32'h0001FFFF),
      byte_row(8'h44, 1'b1),
      // algorithm write restarts the frame
      byte_row(8'h55, 1'b0),
      reg_row(mafc_pkg::CFG_ALGORITHM, {29'h0, mafc_pkg::ALG_MODBUS}),
      byte_row(8'h66, 1'b1)
    };
    snd_idle_pct = 16;
    rcv_stall_pct <= 16;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        quiesce();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_byte(plan[i].data[7:0], plan[i].last, plan[i].typed, plan[i].want);
      end
    end

    // random frames under changing settings and idle patterns
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiesce();
      snd_idle_pct = snd_mode[ph % 4];
      rcv_stall_pct <= rcv_mode[ph % 4];
      alg = 3'($urandom_range(mafc_pkg::ALG_XOR8, mafc_pkg::ALG_MODBUS));
      if ($urandom_range(7) == 0)
        alg = 3'($urandom_range(ALG_RESERVED_TOP, mafc_pkg::ALG_XOR8 + 1));
      case ($urandom_range(7))
        0:       rs = 32'h0;
        1:       rs = 32'h0000FFFF;
        2:       rs = {16'h0, 16'($urandom())};
        default: rs = $urandom_range(6);
      endcase
      case ($urandom_range(7))
        0:       re = 32'hFFFFFFFF;
        1:       re = 32'h0001FFFF;
        2:       re = 32'h0000FFFF;
        3:       re = 32'h0;
        4:       re = {15'h0, 17'($urandom())};
        default: re = $urandom_range(40, 2);
      endcase
      write_reg(mafc_pkg::CFG_ALGORITHM, {29'h0, alg});
      write_reg(mafc_pkg::CFG_RANGE_START, rs);
      write_reg(mafc_pkg::CFG_RANGE_END, re);
      write_reg(mafc_pkg::CFG_BYTE_ORDER, {30'h0, 2'($urandom_range(ORD_RESERVED))});
      // long receiver hold-off while short frames keep coming
      if (ph == 0) hold_cycles <= HOLD_CYCLES;
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        if (ph == 0) flen = $urandom_range(3, 1);
        else begin
          case ($urandom_range(19))
            0:             flen = $urandom_range(64, 33);
            1, 2, 3, 4, 5: flen = $urandom_range(32, 9);
            default:       flen = $urandom_range(8, 1);
          endcase
        end
        for (int k = 0; k < flen; k++)
          send_byte(8'($urandom()), k == flen - 1, 1'b0, '0);
        sent += flen;
      end
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
